>>> sv/mfva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfva_pkg;

   // Field widths that the event and result formats fix.
   localparam int unsigned CHAN_W       = 4;
   localparam int unsigned NOTE_W       = 7;
   localparam int unsigned VOICE_W      = 5;
   localparam int unsigned NUM_CHANNELS = 16;

   // Event codes carried in the request tuser.
   typedef enum logic [2:0] {
      FUNC_NOTE_OFF = 3'd0,
      FUNC_NOTE_ON  = 3'd1,
      FUNC_PROGRAM  = 3'd2,
      FUNC_BANK     = 3'd3,
      FUNC_TIMBRE   = 3'd4
   } func_type;

   // Result kinds carried in the response tuser.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_PATCH = 1'b1;

   // Synth register map.
   localparam logic [8:0] REG_FNUM_LO     = 9'h0a0;
   localparam logic [8:0] REG_KEY_BLOCK   = 9'h0b0;
   localparam logic [8:0] HIGH_BANK_BASE  = 9'h100;
   localparam logic [8:0] VOICES_PER_BANK = 9'd9;
   localparam logic [7:0] KEY_ON_BIT      = 8'h20;

   // Highest note whose pitch the synth reaches within 10 Hz.
   localparam logic [7:0] NOTE_TOP = 8'd114;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PROG,
      ST_SCAN,
      ST_FLUSH,
      ST_EMIT_PATCH,
      ST_EMIT_FLO,
      ST_EMIT_KEYON,
      ST_EMIT_KEYOFF
   } state_type;

   // Access to the voice memory.
   typedef struct packed {
      logic               rd_en;
      logic [VOICE_W-1:0] rd_addr;
      logic               wr_en;
      logic [VOICE_W-1:0] wr_addr;
      logic               wr_busy;
      logic [CHAN_W-1:0]  wr_chan;
      logic [NOTE_W-1:0]  wr_note;
   } voice_req_type;

   // Registered read data of the voice memory.
   typedef struct packed {
      logic              busy;
      logic [CHAN_W-1:0] chan;
      logic [NOTE_W-1:0] note;
   } voice_rsp_type;

   typedef logic [7:0] chan_table_type [NUM_CHANNELS];

   localparam chan_table_type CHAN_BANK_INIT = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

   localparam chan_table_type CHAN_PATCH_INIT = '{
      8'd0, 8'd68, 8'd48, 8'd95, 8'd78, 8'd41, 8'd3, 8'd110,
      8'd122, 8'd36, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

   typedef logic [12:0] note_rom_type [128];

   // Block (upper three bits) and F-number (lower ten bits) per note, tuned for a
   // 49716 Hz synth sample rate. Notes above NOTE_TOP hold zero and are never used.
   localparam note_rom_type NOTE_FREQ_ROM = '{
      {3'd0, 10'd172}, {3'd0, 10'd183}, {3'd0, 10'd194}, {3'd0, 10'd205}, {3'd0, 10'd217},
      {3'd0, 10'd230}, {3'd0, 10'd244}, {3'd0, 10'd258}, {3'd0, 10'd274},
      {3'd0, 10'd290}, {3'd0, 10'd307}, {3'd0, 10'd326}, {3'd0, 10'd345}, {3'd0, 10'd365},
      {3'd0, 10'd387}, {3'd0, 10'd410}, {3'd0, 10'd435}, {3'd0, 10'd460}, {3'd0, 10'd488},
      {3'd0, 10'd517}, {3'd0, 10'd547},
      {3'd0, 10'd580}, {3'd0, 10'd615}, {3'd0, 10'd651}, {3'd0, 10'd690}, {3'd0, 10'd731},
      {3'd0, 10'd774}, {3'd0, 10'd820}, {3'd0, 10'd869}, {3'd0, 10'd921}, {3'd0, 10'd975},
      {3'd1, 10'd517}, {3'd1, 10'd547},
      {3'd1, 10'd580}, {3'd1, 10'd615}, {3'd1, 10'd651}, {3'd1, 10'd690}, {3'd1, 10'd731},
      {3'd1, 10'd774}, {3'd1, 10'd820}, {3'd1, 10'd869}, {3'd1, 10'd921}, {3'd1, 10'd975},
      {3'd2, 10'd517}, {3'd2, 10'd547},
      {3'd2, 10'd580}, {3'd2, 10'd615}, {3'd2, 10'd651}, {3'd2, 10'd690}, {3'd2, 10'd731},
      {3'd2, 10'd774}, {3'd2, 10'd820}, {3'd2, 10'd869}, {3'd2, 10'd921}, {3'd2, 10'd975},
      {3'd3, 10'd517}, {3'd3, 10'd547},
      {3'd3, 10'd580}, {3'd3, 10'd615}, {3'd3, 10'd651}, {3'd3, 10'd690}, {3'd3, 10'd731},
      {3'd3, 10'd774}, {3'd3, 10'd820}, {3'd3, 10'd869}, {3'd3, 10'd921}, {3'd3, 10'd975},
      {3'd4, 10'd517}, {3'd4, 10'd547},
      {3'd4, 10'd580}, {3'd4, 10'd615}, {3'd4, 10'd651}, {3'd4, 10'd690}, {3'd4, 10'd731},
      {3'd4, 10'd774}, {3'd4, 10'd820}, {3'd4, 10'd869}, {3'd4, 10'd921}, {3'd4, 10'd975},
      {3'd5, 10'd517}, {3'd5, 10'd547},
      {3'd5, 10'd580}, {3'd5, 10'd615}, {3'd5, 10'd651}, {3'd5, 10'd690}, {3'd5, 10'd731},
      {3'd5, 10'd774}, {3'd5, 10'd820}, {3'd5, 10'd869}, {3'd5, 10'd921}, {3'd5, 10'd975},
      {3'd6, 10'd517}, {3'd6, 10'd547},
      {3'd6, 10'd580}, {3'd6, 10'd615}, {3'd6, 10'd651}, {3'd6, 10'd690}, {3'd6, 10'd731},
      {3'd6, 10'd774}, {3'd6, 10'd820}, {3'd6, 10'd869}, {3'd6, 10'd921}, {3'd6, 10'd975},
      {3'd7, 10'd517}, {3'd7, 10'd547},
      {3'd7, 10'd580}, {3'd7, 10'd615}, {3'd7, 10'd651}, {3'd7, 10'd690}, {3'd7, 10'd731},
      {3'd7, 10'd774}, {3'd7, 10'd820}, {3'd7, 10'd869}, {3'd7, 10'd921}, {3'd7, 10'd975},
      13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
      13'd0, 13'd0, 13'd0, 13'd0, 13'd0
   };

   // Register address of a voice: voices above the first nine live in the upper bank.
   function automatic logic [8:0] voice_reg_addr(input logic [VOICE_W-1:0] v,
                                                 input logic [8:0] base);
      logic [8:0] off;
      if (9'(v) < VOICES_PER_BANK) begin
         off = 9'(v);
      end else begin
         off = HIGH_BANK_BASE + 9'(v) - VOICES_PER_BANK;
      end
      return off + base;
   endfunction

endpackage

`default_nettype wire

>>> sv/midi_to_fm_voice_allocator.sv
// An event is taken in ST_IDLE and decoded in ST_DECODE; a program change adds a timbre read.
// Note and patch events then walk the voice memory one entry a cycle, but a patch scan waits
// while a held result finds the output full. A note-on that claims a voice ends with three results.
// The single read port of the voice memory sets the scan rate; results wait in an output register.
// Synchronous reset frees all voices, loads the default channel banks and patches and marks
// every timbre map entry as zero; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module midi_to_fm_voice_allocator
   import mfva_pkg::*;
#(
   parameter int unsigned NUM_VOICES = 18
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // channel, note_or_program, bank_value
   input  wire logic [2:0]  req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // reg_addr, reg_data, voice, bank, patch
   output logic             rsp_tuser,   // kind
   output logic             rsp_tlast
);

   localparam int unsigned VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

   state_type         state_ff, state_in;
   func_type          func_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [7:0]        nop_ff;
   logic [7:0]        bv_ff;

   logic [VIDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [VIDX_W-1:0] pend_idx_ff, pend_idx_in;

   logic              rsp_valid_ff;
   logic              rsp_kind_ff;
   logic [8:0]        rsp_addr_ff;
   logic [7:0]        rsp_data_ff;
   logic [VOICE_W-1:0] rsp_voice_ff;
   logic [7:0]        rsp_bank_ff;
   logic [7:0]        rsp_patch_ff;
   logic              rsp_last_ff;

   chan_table_type    chan_bank_ff;
   chan_table_type    chan_patch_ff;

   logic [7:0]        timbre_mem [256];
   logic [255:0]      timbre_vld_ff;
   logic [7:0]        timbre_q_ff;
   logic              timbre_q_vld_ff;
   logic [7:0]        timbre_val;

   voice_req_type     vreq;
   voice_rsp_type     vrsp;

   logic              push;
   logic              push_kind;
   logic [8:0]        push_addr;
   logic [7:0]        push_data;
   logic [VOICE_W-1:0] push_voice;
   logic [7:0]        push_bank;
   logic [7:0]        push_patch;
   logic              push_last;

   logic              timbre_rd_en;
   logic              timbre_wr_en;
   logic              bank_wr_en;
   logic [7:0]        bank_wr_val;
   logic              patch_wr_en;

   logic              req_accept;
   logic              out_free;
   logic              note_ok;
   logic [12:0]       rom_word;
   logic [2:0]        blk;
   logic [9:0]        fnum;
   logic              is_last;
   logic              chan_match;
   logic              match;
   logic              scan_go;
   logic [7:0]        cur_bank;
   logic [7:0]        cur_patch;
   logic [VOICE_W-1:0] scan_voice;

   mfva_voice_mem #(
      .NUM_VOICES(NUM_VOICES)
   ) u_voice_mem (
      .clock(clock),
      .reset(reset),
      .vreq (vreq),
      .vrsp (vrsp)
   );

   // Handshake and shared decode.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign note_ok    = (nop_ff <= NOTE_TOP);
   assign rom_word   = NOTE_FREQ_ROM[nop_ff[6:0]];
   assign blk        = rom_word[12:10];
   assign fnum       = rom_word[9:0];
   assign cur_bank   = chan_bank_ff[chan_ff];
   assign cur_patch  = chan_patch_ff[chan_ff];
   assign timbre_val = timbre_q_vld_ff ? timbre_q_ff : 8'd0;
   assign scan_voice = VOICE_W'(scan_idx_ff);

   // Test of the voice entry most recently read, the one at scan_idx_ff.
   assign is_last    = (scan_idx_ff == LAST_VOICE);
   assign chan_match = vrsp.busy && (vrsp.chan == chan_ff);

   always_comb begin
      case (func_ff)
         FUNC_NOTE_ON:  match = !vrsp.busy;
         FUNC_NOTE_OFF: match = chan_match && (vrsp.note == nop_ff[6:0]);
         default:       match = chan_match;
      endcase
   end

   // A re-request scan waits only when a held request must go out and the output is full.
   assign scan_go = !(match && pend_valid_ff) || out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (func_ff)
               FUNC_NOTE_OFF, FUNC_NOTE_ON: state_in = note_ok ? ST_SCAN : ST_IDLE;
               FUNC_PROGRAM:                state_in = ST_PROG;
               FUNC_BANK:                   state_in = ST_SCAN;
               default:                     state_in = ST_IDLE;
            endcase
         end
         ST_PROG: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (func_ff inside {FUNC_NOTE_OFF, FUNC_NOTE_ON}) begin
               if (match) begin
                  state_in = (func_ff == FUNC_NOTE_ON) ? ST_EMIT_PATCH : ST_EMIT_KEYOFF;
               end else if (is_last) begin
                  state_in = ST_IDLE;
               end
            end else if (scan_go && is_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = ST_IDLE;
         end
         ST_EMIT_PATCH: begin
            if (out_free) state_in = ST_EMIT_FLO;
         end
         ST_EMIT_FLO: begin
            if (out_free) state_in = ST_EMIT_KEYON;
         end
         ST_EMIT_KEYON, ST_EMIT_KEYOFF: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs: memory accesses, table writes and results.
   always_comb begin
      vreq          = '0;
      timbre_rd_en  = 1'b0;
      timbre_wr_en  = 1'b0;
      bank_wr_en    = 1'b0;
      bank_wr_val   = bv_ff;
      patch_wr_en   = 1'b0;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      push          = 1'b0;
      push_kind     = KIND_WRITE;
      push_addr     = 9'd0;
      push_data     = 8'd0;
      push_voice    = scan_voice;
      push_bank     = 8'd0;
      push_patch    = 8'd0;
      push_last     = 1'b0;
      case (state_ff)
         ST_DECODE: begin
            case (func_ff)
               FUNC_NOTE_OFF, FUNC_NOTE_ON: begin
                  vreq.rd_en    = note_ok;
                  scan_idx_in   = '0;
                  pend_valid_in = 1'b0;
               end
               FUNC_PROGRAM: begin
                  timbre_rd_en = 1'b1;
               end
               FUNC_BANK: begin
                  bank_wr_en    = 1'b1;
                  vreq.rd_en    = 1'b1;
                  scan_idx_in   = '0;
                  pend_valid_in = 1'b0;
               end
               FUNC_TIMBRE: begin
                  timbre_wr_en = 1'b1;
               end
               default: ;
            endcase
         end
         ST_PROG: begin
            patch_wr_en   = 1'b1;
            bank_wr_en    = 1'b1;
            bank_wr_val   = timbre_val;
            vreq.rd_en    = 1'b1;
            scan_idx_in   = '0;
            pend_valid_in = 1'b0;
         end
         ST_SCAN: begin
            if (func_ff inside {FUNC_NOTE_OFF, FUNC_NOTE_ON}) begin
               if (match) begin
                  // Claim or release the voice; a released voice also forgets its note.
                  vreq.wr_en   = 1'b1;
                  vreq.wr_addr = scan_voice;
                  vreq.wr_busy = (func_ff == FUNC_NOTE_ON);
                  vreq.wr_chan = (func_ff == FUNC_NOTE_ON) ? chan_ff : '0;
                  vreq.wr_note = (func_ff == FUNC_NOTE_ON) ? nop_ff[6:0] : '0;
               end else if (!is_last) begin
                  vreq.rd_en  = 1'b1;
                  scan_idx_in = scan_idx_ff + VIDX_W'(1);
               end
            end else if (scan_go) begin
               // Hold each match until the next one shows whether it ends the event.
               if (match) begin
                  push          = pend_valid_ff;
                  push_kind     = KIND_PATCH;
                  push_voice    = VOICE_W'(pend_idx_ff);
                  push_bank     = cur_bank;
                  push_patch    = cur_patch;
                  pend_valid_in = 1'b1;
                  pend_idx_in   = scan_idx_ff;
               end
               if (!is_last) begin
                  vreq.rd_en  = 1'b1;
                  scan_idx_in = scan_idx_ff + VIDX_W'(1);
               end
            end
            vreq.rd_addr = VOICE_W'(scan_idx_in);
         end
         ST_FLUSH: begin
            // The held request stays until the output register takes it.
            push          = pend_valid_ff && out_free;
            push_kind     = KIND_PATCH;
            push_voice    = VOICE_W'(pend_idx_ff);
            push_bank     = cur_bank;
            push_patch    = cur_patch;
            push_last     = 1'b1;
            if (out_free) pend_valid_in = 1'b0;
         end
         ST_EMIT_PATCH: begin
            push       = out_free;
            push_kind  = KIND_PATCH;
            push_bank  = cur_bank;
            push_patch = cur_patch;
         end
         ST_EMIT_FLO: begin
            push      = out_free;
            push_addr = voice_reg_addr(scan_voice, REG_FNUM_LO);
            push_data = fnum[7:0];
         end
         ST_EMIT_KEYON: begin
            push      = out_free;
            push_addr = voice_reg_addr(scan_voice, REG_KEY_BLOCK);
            push_data = KEY_ON_BIT | {3'b000, blk, fnum[9:8]};
            push_last = 1'b1;
         end
         ST_EMIT_KEYOFF: begin
            push      = out_free;
            push_addr = voice_reg_addr(scan_voice, REG_KEY_BLOCK);
            push_data = {3'b000, blk, fnum[9:8]};
            push_last = 1'b1;
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Event fields, scan position and the output register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= func_type'(req_tuser);
         chan_ff <= req_tdata[3:0];
         nop_ff  <= req_tdata[11:4];
         bv_ff   <= req_tdata[19:12];
      end
      scan_idx_ff <= scan_idx_in;
      pend_idx_ff <= pend_idx_in;
      if (push) begin
         rsp_kind_ff  <= push_kind;
         rsp_addr_ff  <= push_addr;
         rsp_data_ff  <= push_data;
         rsp_voice_ff <= push_voice;
         rsp_bank_ff  <= push_bank;
         rsp_patch_ff <= push_patch;
         rsp_last_ff  <= push_last;
      end
   end

   // Per-channel bank and patch.
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_bank_ff  <= CHAN_BANK_INIT;
         chan_patch_ff <= CHAN_PATCH_INIT;
      end else begin
         if (bank_wr_en) chan_bank_ff[chan_ff] <= bank_wr_val;
         if (patch_wr_en) chan_patch_ff[chan_ff] <= nop_ff;
      end
   end

   // Timbre map memory; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (timbre_wr_en) timbre_mem[nop_ff] <= bv_ff;
      if (timbre_rd_en) timbre_q_ff <= timbre_mem[nop_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timbre_vld_ff   <= '0;
         timbre_q_vld_ff <= 1'b0;
      end else begin
         if (timbre_wr_en) timbre_vld_ff[nop_ff] <= 1'b1;
         if (timbre_rd_en) timbre_q_vld_ff <= timbre_vld_ff[nop_ff];
      end
   end

   // Result channel.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_patch_ff, rsp_bank_ff, rsp_voice_ff, rsp_data_ff,
                        rsp_addr_ff};

   // The scan never runs past the last voice.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= LAST_VOICE))
      else $error("voice scan index out of range");

   // Voice entries change only at the voice that a note event selects.
   assert property (@(posedge clock) disable iff (reset)
      vreq.wr_en |-> ((state_ff == ST_SCAN) && match && (vreq.wr_addr == scan_voice)))
      else $error("unexpected voice memory write");

   // A result is never loaded over one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result overwritten in output register");

   // The final result of an event returns the controller to idle.
   assert property (@(posedge clock) disable iff (reset)
      (push && push_last) |=> (state_ff == ST_IDLE))
      else $error("controller busy after final result");

   // No held patch request survives into the next event.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !pend_valid_ff)
      else $error("held patch request lost at new event");

endmodule

`default_nettype wire

>>> sv/mfva_voice_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module mfva_voice_mem
   import mfva_pkg::*;
#(
   parameter int unsigned NUM_VOICES = 18
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire voice_req_type vreq,
   output voice_rsp_type      vrsp
);

   localparam int unsigned VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [NOTE_W-1:0] note;
   } voice_entry_type;

   voice_entry_type       mem [NUM_VOICES];
   logic [NUM_VOICES-1:0] busy_ff;
   voice_rsp_type         rsp_ff;
   logic [VIDX_W-1:0]     rd_idx;
   logic [VIDX_W-1:0]     wr_idx;

   assign rd_idx = vreq.rd_addr[VIDX_W-1:0];
   assign wr_idx = vreq.wr_addr[VIDX_W-1:0];
   assign vrsp   = rsp_ff;

   // Channel and note of each voice, one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (vreq.wr_en) begin
         mem[wr_idx] <= '{chan: vreq.wr_chan, note: vreq.wr_note};
      end
      if (vreq.rd_en) begin
         rsp_ff.busy <= busy_ff[rd_idx];
         rsp_ff.chan <= mem[rd_idx].chan;
         rsp_ff.note <= mem[rd_idx].note;
      end
   end

   // Busy flags; reset frees every voice at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (vreq.wr_en) begin
         busy_ff[wr_idx] <= vreq.wr_busy;
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mfva_pkg::*;

   localparam int unsigned VOICES         = 18;
   localparam longint unsigned SAMPLE_RATE = 49716;
   localparam longint unsigned PITCH_TOL   = 64'd4096000000000;
   localparam int unsigned RANDOM_ITEMS   = 245;
   localparam int unsigned CALM_TAIL      = 40;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 30;

   // Event codes that the block ignores.
   localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

   // Marks a stimulus row that is checked against the predictor.
   localparam int PREDICTED = -1;

   // 440 Hz times each semitone ratio, in units of 1e-8 Hz.
   localparam longint unsigned SEMITONE_HZ [12] = '{
      64'd44000000000, 64'd46616376152, 64'd49388330126, 64'd52325113060,
      64'd55436526195, 64'd58732953583, 64'd62225396744, 64'd65925511383,
      64'd69845646287, 64'd73998884542, 64'd78399087196, 64'd83060939516
   };

   // One command toward the synth, in the order of the response fields.
   typedef struct packed {
      logic       kind;
      logic [8:0] reg_addr;
      logic [7:0] reg_data;
      logic [4:0] voice;
      logic [7:0] bank;
      logic [7:0] patch;
      logic       last;
   } fm_cmd_type;

   // One directed MIDI message with the number of typed-in commands it causes.
   typedef struct {
      logic [2:0] func;
      logic [3:0] chan;
      logic [7:0] nop;
      logic [7:0] bval;
      int         n_typed;
   } midi_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // channel, note_or_program, bank_value
   logic [2:0]  req_tuser = '0;   // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // reg_addr, reg_data, voice, bank, patch
   logic        rsp_tuser;        // kind
   logic        rsp_tlast;

   // Predictor state.
   logic        voice_busy [VOICES];
   logic [3:0]  voice_chan [VOICES];
   logic [6:0]  voice_note [VOICES];
   logic [7:0]  chan_bank [16];
   logic [7:0]  chan_patch [16];
   logic [7:0]  timbre_map [256];
   logic [12:0] pitch_word [128];
   logic        pitch_ok [128];

   fm_cmd_type fm_cmd_q [$];
   fm_cmd_type msg_cmds [$];
   int      typed_idx = 0;
   int      error_count = 0;
   int      idle_cycles = 0;
   int      ready_hold = 0;
   bit      stall_enable = 1'b1;

   // Commands that can be read straight off the spec: A440 on channel 0 and its key-off.
   fm_cmd_type typed_cmds [4] = '{
      '{KIND_PATCH, 9'h000, 8'h00, 5'd0, 8'd0, 8'd0, 1'b0},
      '{KIND_WRITE, 9'h0a0, 8'h44, 5'd0, 8'd0, 8'd0, 1'b0},
      '{KIND_WRITE, 9'h0b0, 8'h32, 5'd0, 8'd0, 8'd0, 1'b1},
      '{KIND_WRITE, 9'h0b0, 8'h12, 5'd0, 8'd0, 8'd0, 1'b1}
   };

   midi_row_type dir_rows [25] = '{
      '{FUNC_NOTE_ON,  4'd0,  8'd69,  8'h00, 3},
      '{FUNC_NOTE_ON,  4'd9,  8'd0,   8'hff, PREDICTED},
      '{FUNC_NOTE_ON,  4'd15, 8'd114, 8'h00, PREDICTED},
      '{FUNC_NOTE_ON,  4'd3,  8'd115, 8'h00, 0},
      '{FUNC_NOTE_ON,  4'd3,  8'd127, 8'h00, 0},
      '{FUNC_NOTE_ON,  4'd3,  8'd128, 8'h00, 0},
      '{FUNC_NOTE_ON,  4'd3,  8'd255, 8'h00, 0},
      '{FUNC_NOTE_OFF, 4'd0,  8'd69,  8'h00, 1},
      '{FUNC_NOTE_OFF, 4'd0,  8'd69,  8'h00, 0},
      '{FUNC_NOTE_OFF, 4'd1,  8'd0,   8'h00, 0},
      '{FUNC_NOTE_OFF, 4'd15, 8'd200, 8'h00, 0},
      '{FUNC_TIMBRE,   4'd0,  8'd255, 8'hff, 0},
      '{FUNC_TIMBRE,   4'd15, 8'd0,   8'haa, 0},
      '{FUNC_PROGRAM,  4'd9,  8'd0,   8'h00, PREDICTED},
      '{FUNC_PROGRAM,  4'd9,  8'd255, 8'h00, PREDICTED},
      '{FUNC_BANK,     4'd15, 8'd0,   8'hff, PREDICTED},
      '{FUNC_BANK,     4'd15, 8'd0,   8'h00, PREDICTED},
      '{FUNC_PROGRAM,  4'd4,  8'd7,   8'h00, 0},
      '{FUNC_SPARE_5,  4'd15, 8'd255, 8'hff, 0},
      '{FUNC_SPARE_6,  4'd0,  8'd0,   8'h00, 0},
      '{FUNC_SPARE_7,  4'd7,  8'h5a,  8'ha5, 0},
      '{FUNC_NOTE_ON,  4'd15, 8'd114, 8'h00, PREDICTED},
      '{FUNC_BANK,     4'd15, 8'd0,   8'h55, PREDICTED},
      '{FUNC_NOTE_OFF, 4'd15, 8'd114, 8'h00, PREDICTED},
      '{FUNC_NOTE_OFF, 4'd9,  8'd0,   8'h00, PREDICTED}
   };

   midi_to_fm_voice_allocator #(
      .NUM_VOICES (VOICES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Best block and F-number per note, searched the same way the synth tuning is defined.
   function automatic void build_pitch_table();
      longint unsigned fq, y, step, f0, x, d, best;
      int unsigned oct, bb, bf;
      for (int n = 0; n < 128; n++) begin
         oct = (n + 3) / 12;
         fq = SEMITONE_HZ[(n + 3) % 12];
         best = '1;
         bb = 0;
         bf = 0;
         if (oct >= 6) fq = fq << (oct - 6);
         else fq = fq >> (6 - oct);
         y = fq << 12;
         for (int b = 0; b < 8; b++) begin
            step = (SAMPLE_RATE << b) * 64'd390625;
            f0 = y / step;
            if (f0 > 1023) f0 = 1023;
            for (longint unsigned c = f0; c <= f0 + 1 && c <= 1023; c++) begin
               x = c * step;
               d = (x > y) ? x - y : y - x;
               if (d < best) begin
                  best = d;
                  bb = b;
                  bf = int'(c);
               end
            end
         end
         pitch_ok[n] = (best < PITCH_TOL);
         pitch_word[n] = {3'(bb), 10'(bf)};
      end
   endfunction

   function automatic void reset_predictor();
      logic [7:0] gm_patch [10] = '{8'd0, 8'd68, 8'd48, 8'd95, 8'd78, 8'd41, 8'd3,
                                    8'd110, 8'd122, 8'd36};
      for (int v = 0; v < VOICES; v++) begin
         voice_busy[v] = 1'b0;
         voice_chan[v] = '0;
         voice_note[v] = '0;
      end
      for (int c = 0; c < 16; c++) begin
         chan_bank[c] = (c == 9) ? 8'd127 : 8'd0;
         chan_patch[c] = (c < 10) ? gm_patch[c] : 8'd0;
      end
      for (int i = 0; i < 256; i++) timbre_map[i] = '0;
      build_pitch_table();
   endfunction

   // Synth register of a voice: voices past the first nine sit in the upper bank.
   function automatic logic [8:0] synth_reg(input int v, input logic [8:0] base);
      logic [8:0] off;
      off = (v < 9) ? 9'(v) : HIGH_BANK_BASE + 9'(v - 9);
      return off + base;
   endfunction

   function automatic fm_cmd_type patch_cmd(input int v, input logic [3:0] ch);
      return '{KIND_PATCH, 9'd0, 8'd0, 5'(v), chan_bank[ch], chan_patch[ch], 1'b0};
   endfunction

   function automatic fm_cmd_type write_cmd(input int v, input logic [8:0] base,
                                            input logic [7:0] data);
      return '{KIND_WRITE, synth_reg(v, base), data, 5'(v), 8'd0, 8'd0, 1'b0};
   endfunction

   // Appends one command to the commands of the current message.
   function automatic void add_msg_cmd(input fm_cmd_type c);
      msg_cmds.insert(msg_cmds.size(), c);
   endfunction

   // Works out the commands that one MIDI message causes and updates the voice state.
   function automatic void predict_fm_cmds(input logic [2:0] fn, input logic [3:0] ch,
                                           input logic [7:0] nop, input logic [7:0] bv);
      int hit;
      logic [2:0] blk;
      logic [9:0] fnum;
      logic [7:0] key_bits;
      msg_cmds.delete();
      hit = -1;
      if (fn == FUNC_NOTE_OFF || fn == FUNC_NOTE_ON) begin
         if (nop < 8'd128 && pitch_ok[nop[6:0]]) begin
            {blk, fnum} = pitch_word[nop[6:0]];
            key_bits = {3'd0, blk, fnum[9:8]};
            for (int v = 0; v < VOICES && hit < 0; v++) begin
               if (fn == FUNC_NOTE_OFF && voice_busy[v] && voice_chan[v] == ch &&
                   voice_note[v] == nop[6:0]) hit = v;
               if (fn == FUNC_NOTE_ON && !voice_busy[v]) hit = v;
            end
            if (hit >= 0 && fn == FUNC_NOTE_OFF) begin
               voice_busy[hit] = 1'b0;
               voice_chan[hit] = '0;
               voice_note[hit] = '0;
               add_msg_cmd(write_cmd(hit, REG_KEY_BLOCK, key_bits));
            end else if (hit >= 0) begin
               voice_busy[hit] = 1'b1;
               voice_chan[hit] = ch;
               voice_note[hit] = nop[6:0];
               add_msg_cmd(patch_cmd(hit, ch));
               add_msg_cmd(write_cmd(hit, REG_FNUM_LO, fnum[7:0]));
               add_msg_cmd(write_cmd(hit, REG_KEY_BLOCK, KEY_ON_BIT + key_bits));
            end
         end
      end else if (fn == FUNC_PROGRAM || fn == FUNC_BANK) begin
         if (fn == FUNC_PROGRAM) begin
            chan_patch[ch] = nop;
            chan_bank[ch] = timbre_map[nop];
         end else begin
            chan_bank[ch] = bv;
         end
         for (int v = 0; v < VOICES; v++)
            if (voice_busy[v] && voice_chan[v] == ch) add_msg_cmd(patch_cmd(v, ch));
      end else if (fn == FUNC_TIMBRE) begin
         timbre_map[nop] = bv;
      end
      if (msg_cmds.size() > 0) msg_cmds[msg_cmds.size() - 1].last = 1'b1;
   endfunction

   function automatic string cmd_text(input fm_cmd_type c);
      return $sformatf("kind=%0d addr=%03h data=%02h voice=%0d bank=%0d patch=%0d last=%0d",
                       c.kind, c.reg_addr, c.reg_data, c.voice, c.bank, c.patch, c.last);
   endfunction

   function automatic int random_busy_voice();
      int picks [$];
      for (int v = 0; v < VOICES; v++) if (voice_busy[v]) picks.insert(picks.size(), v);
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(0, picks.size() - 1)];
   endfunction

   // Mostly well-formed playing: note-ons, note-offs of sounding notes and patch changes
   // on busy channels and timbre map writes, mixed with raw noise and a few broken note-offs.
   function automatic void random_midi(input bit filling, output logic [2:0] fn,
                                       output logic [3:0] ch, output logic [7:0] nop,
                                       output logic [7:0] bv);
      int r, v, pick;
      r = $urandom_range(0, 99);
      if (filling && r >= 50 && r < 75) r = 30;
      fn = FUNC_NOTE_ON;
      ch = 4'($urandom_range(0, 15));
      nop = 8'($urandom_range(0, 255));
      bv = 8'($urandom_range(0, 255));
      v = random_busy_voice();
      if (r < 15) begin
         fn = 3'($urandom_range(0, 7));
      end else if (r < 50) begin
         if ($urandom_range(0, 1) == 0) ch = 4'($urandom_range(0, 3));
         pick = $urandom_range(0, 9);
         if (pick < 5) nop = 8'($urandom_range(36, 84));
         else if (pick < 8) nop = 8'($urandom_range(60, 63));
         else nop = 8'($urandom_range(0, 127));
      end else if (r < 75) begin
         fn = FUNC_NOTE_OFF;
         nop = 8'($urandom_range(0, 127));
         if (v >= 0 && $urandom_range(0, 9) != 0) begin
            ch = voice_chan[v];
            nop = {1'b0, voice_note[v]};
         end
      end else if (r < 93) begin
         fn = (r < 85) ? FUNC_PROGRAM : FUNC_BANK;
         if (v >= 0 && $urandom_range(0, 3) != 0) ch = voice_chan[v];
      end else begin
         fn = FUNC_TIMBRE;
      end
   endfunction

   // Offers one message, waits for the transaction and queues what it must cause.
   task automatic send_midi(input logic [2:0] fn, input logic [3:0] ch, input logic [7:0] nop,
                            input logic [7:0] bv, input int n_typed);
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {4'd0, bv, nop, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_fm_cmds(fn, ch, nop, bv);
      if (n_typed == PREDICTED) begin
         foreach (msg_cmds[i]) fm_cmd_q.insert(fm_cmd_q.size(), msg_cmds[i]);
      end else begin
         for (int i = 0; i < n_typed; i++) begin
            fm_cmd_q.insert(fm_cmd_q.size(), typed_cmds[typed_idx]);
            typed_idx++;
         end
      end
   endtask

   task automatic sender_gap(input bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Receiver: runs of ready broken up by stall bursts while stalling is enabled.
   always @(posedge clock) begin
      if (!stall_enable) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_tready && $urandom_range(0, 2) == 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 15);
      end
   end

   // Each response transaction is compared with the oldest expected command.
   always @(posedge clock) begin
      fm_cmd_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[8:0], rsp_tdata[16:9], rsp_tdata[21:17],
                rsp_tdata[29:22], rsp_tdata[37:30], rsp_tlast};
         if (fm_cmd_q.size() == 0) begin
            if (error_count < 10) $display("unexpected command: %s", cmd_text(got));
            error_count++;
         end else begin
            want = fm_cmd_q[0];
            fm_cmd_q.delete(0);
            if (got !== want) begin
               if (error_count < 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("   expected %s", cmd_text(want));
                  $display("   actual   %s", cmd_text(got));
               end
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [2:0] fn;
      logic [3:0] ch;
      logic [7:0] nop, bv;
      bit calm;
      reset_predictor();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed messages.
      foreach (dir_rows[i]) begin
         sender_gap(1'b1);
         send_midi(dir_rows[i].func, dir_rows[i].chan, dir_rows[i].nop, dir_rows[i].bval,
                   dir_rows[i].n_typed);
      end

      // Random playing; a middle stretch holds back note-offs so the voice pool runs full.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= RANDOM_ITEMS - CALM_TAIL);
         if (calm) stall_enable = 1'b0;
         random_midi(n >= 60 && n < 110, fn, ch, nop, bv);
         sender_gap(!calm);
         send_midi(fn, ch, nop, bv, PREDICTED);
      end
      req_tvalid <= 1'b0;

      while (fm_cmd_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
